/* rtl/core/mbq_pkg.sv */
// Shared types, register indexes and the control program of the biquad sequencer.
// Depends on nothing; used by multichannel_biquad_filter.
`timescale 1ns / 1ps

package mbq_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_B0   = 3'd0;
  localparam logic [2:0] REG_B1   = 3'd1;
  localparam logic [2:0] REG_B2   = 3'd2;
  localparam logic [2:0] REG_A1   = 3'd3;
  localparam logic [2:0] REG_A2   = 3'd4;
  localparam logic [2:0] REG_GAIN = 3'd5;

  localparam int COEF_W   = 20;
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int ACC_W    = 40;

  localparam logic signed [COEF_W-1:0] B0_RESET   = 20'sd65536;
  localparam logic [GAIN_W-1:0]        GAIN_RESET = 16'd16384;

  // Coefficient operand select.
  localparam logic [2:0] A_B0   = 3'd0;
  localparam logic [2:0] A_B1   = 3'd1;
  localparam logic [2:0] A_B2   = 3'd2;
  localparam logic [2:0] A_A1   = 3'd3;
  localparam logic [2:0] A_A2   = 3'd4;
  localparam logic [2:0] A_GAIN = 3'd5;

  // Sample operand select.
  localparam logic [2:0] S_X  = 3'd0;
  localparam logic [2:0] S_X1 = 3'd1;
  localparam logic [2:0] S_X2 = 3'd2;
  localparam logic [2:0] S_Y1 = 3'd3;
  localparam logic [2:0] S_Y2 = 3'd4;
  localparam logic [2:0] S_Y  = 3'd5;

  // Accumulator operations.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Jump conditions.
  localparam logic [1:0] COND_NEVER    = 2'd0;
  localparam logic [1:0] COND_NO_IN    = 2'd1;
  localparam logic [1:0] COND_OUT_BUSY = 2'd2;
  localparam logic [1:0] COND_ALWAYS   = 2'd3;

  localparam logic [3:0] STEP_IDLE = 4'd0;
  localparam logic [3:0] STEP_OUT  = 4'd9;

  typedef struct packed {
    logic       take_in;
    logic       mul_en;
    logic [2:0] a_sel;
    logic [2:0] s_sel;
    logic [1:0] acc_op;
    logic       y_ld;
    logic       out_ld;
    logic [1:0] cond;
    logic [3:0] target;
    logic       last;
  } uc_word_t;

  // Control program: one word per step.
  function automatic uc_word_t uc_rom(input logic [3:0] step);
    uc_word_t w;
    w = '0;
    case (step)
      4'd0: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_IN;
        w.target  = STEP_IDLE;
      end
      4'd1: begin
        w.mul_en = 1'b1; w.a_sel = A_B0; w.s_sel = S_X;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.a_sel = A_B1; w.s_sel = S_X1; w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.mul_en = 1'b1; w.a_sel = A_B2; w.s_sel = S_X2; w.acc_op = ACC_ADD;
      end
      4'd4: begin
        w.mul_en = 1'b1; w.a_sel = A_A1; w.s_sel = S_Y1; w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.a_sel = A_A2; w.s_sel = S_Y2; w.acc_op = ACC_SUB;
      end
      4'd6: begin
        w.acc_op = ACC_SUB;
      end
      4'd7: begin
        w.y_ld = 1'b1;
      end
      4'd8: begin
        w.mul_en = 1'b1; w.a_sel = A_GAIN; w.s_sel = S_Y;
      end
      4'd9: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_OUT;
        w.last   = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sh7fff;
    end else if (v < -24'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/core/multichannel_biquad_filter.sv */
// Multichannel direct form I biquad with one shared multiplier under microcode control.
// Depends on mbq_pkg for the control program, codes and saturation.
// Items pass one at a time through the ten-step program around the single multiplier;
// a new item is taken only after the last one has been handed to the output register,
// and a stalled output holds the final step until the result register frees.
// Reset (synchronous): coefficients return to unity filter and unity gain, all channel
// histories clear at once and the channel counter returns to channel 0.
`timescale 1ns / 1ps

module multichannel_biquad_filter #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [19:0]         cfg_data,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  sample_in,
  // Output channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  sample_out,
  output logic [3:0]          channel
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

  // Configuration registers.
  logic signed [mbq_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [mbq_pkg::GAIN_W-1:0]        out_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0  <= mbq_pkg::B0_RESET;
      coef_b1  <= '0;
      coef_b2  <= '0;
      coef_a1  <= '0;
      coef_a2  <= '0;
      out_gain <= mbq_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mbq_pkg::REG_B0:   coef_b0  <= cfg_data;
        mbq_pkg::REG_B1:   coef_b1  <= cfg_data;
        mbq_pkg::REG_B2:   coef_b2  <= cfg_data;
        mbq_pkg::REG_A1:   coef_a1  <= cfg_data;
        mbq_pkg::REG_A2:   coef_a2  <= cfg_data;
        mbq_pkg::REG_GAIN: out_gain <= cfg_data[mbq_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: step counter and the control word it selects.
  logic [3:0]        step, step_next;
  mbq_pkg::uc_word_t uc;
  logic              jump;
  logic              out_busy;
  logic              in_take;
  logic              out_load;

  assign uc       = mbq_pkg::uc_rom(step);
  assign out_busy = out_valid && out_stall;
  assign in_stall = !uc.take_in || rst;
  assign in_take  = uc.take_in && in_valid;
  assign out_load = uc.out_ld && !out_busy;

  always_comb begin
    case (uc.cond)
      mbq_pkg::COND_NO_IN:    jump = !in_valid;
      mbq_pkg::COND_OUT_BUSY: jump = out_busy;
      mbq_pkg::COND_ALWAYS:   jump = 1'b1;
      default:                jump = 1'b0;
    endcase
    if (jump) begin
      step_next = uc.target;
    end else if (uc.last) begin
      step_next = mbq_pkg::STEP_IDLE;
    end else begin
      step_next = step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mbq_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Per-channel history, cleared at reset.
  logic signed [15:0] x1_mem [NUM_CHANNELS];
  logic signed [15:0] x2_mem [NUM_CHANNELS];
  logic signed [15:0] y1_mem [NUM_CHANNELS];
  logic signed [15:0] y2_mem [NUM_CHANNELS];
  logic [CH_W-1:0]    ch;

  logic signed [15:0] x_reg;
  logic signed [15:0] y_reg;
  logic signed [15:0] y_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        x1_mem[i] <= '0;
        x2_mem[i] <= '0;
        y1_mem[i] <= '0;
        y2_mem[i] <= '0;
      end
    end else if (uc.y_ld) begin
      x2_mem[ch] <= x1_mem[ch];
      x1_mem[ch] <= x_reg;
      y2_mem[ch] <= y1_mem[ch];
      y1_mem[ch] <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_reg <= sample_in;
    end
    if (uc.y_ld) begin
      y_reg <= y_sat;
    end
  end

  // Shared multiplier with a registered product.
  logic signed [mbq_pkg::COEF_W-1:0]   mul_a;
  logic signed [15:0]                  mul_b;
  logic signed [mbq_pkg::PROD_W-1:0]   prod;

  always_comb begin
    case (uc.a_sel)
      mbq_pkg::A_B0:   mul_a = coef_b0;
      mbq_pkg::A_B1:   mul_a = coef_b1;
      mbq_pkg::A_B2:   mul_a = coef_b2;
      mbq_pkg::A_A1:   mul_a = coef_a1;
      mbq_pkg::A_A2:   mul_a = coef_a2;
      mbq_pkg::A_GAIN: mul_a = signed'({4'b0000, out_gain});
      default:         mul_a = '0;
    endcase
    case (uc.s_sel)
      mbq_pkg::S_X:  mul_b = x_reg;
      mbq_pkg::S_X1: mul_b = x1_mem[ch];
      mbq_pkg::S_X2: mul_b = x2_mem[ch];
      mbq_pkg::S_Y1: mul_b = y1_mem[ch];
      mbq_pkg::S_Y2: mul_b = y2_mem[ch];
      mbq_pkg::S_Y:  mul_b = y_reg;
      default:       mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Accumulator: the five filter terms are summed exactly.
  logic signed [mbq_pkg::ACC_W-1:0] acc;
  logic signed [mbq_pkg::ACC_W-1:0] prod_ext;
  logic signed [mbq_pkg::ACC_W-1:0] acc_rnd;
  logic signed [mbq_pkg::PROD_W-1:0] gain_rnd;
  logic signed [15:0]               out_sat;

  assign prod_ext = mbq_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    case (uc.acc_op)
      mbq_pkg::ACC_LOAD: acc <= prod_ext;
      mbq_pkg::ACC_ADD:  acc <= acc + prod_ext;
      mbq_pkg::ACC_SUB:  acc <= acc - prod_ext;
      default:           acc <= acc;
    endcase
  end

  // Round half up by 2^-16, then saturate; this is the stored output.
  assign acc_rnd = acc + 40'sd32768;
  assign y_sat   = mbq_pkg::sat16(signed'(acc_rnd[39:16]));

  // Gain product rounded half up by 2^-14, then saturated.
  assign gain_rnd = prod + 36'sd8192;
  assign out_sat  = mbq_pkg::sat16(24'(signed'(gain_rnd[35:14])));

  // Output register and channel counter. The counter advances when the
  // result of the current channel is handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ch        <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        ch        <= (ch == CH_LAST) ? '0 : ch + 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= out_sat;
      channel    <= 4'(ch);
    end
  end

endmodule

/* verif/tb_multichannel_biquad_filter.sv */
// Self-checking testbench for the multichannel direct form I biquad filter.
// Depends on mbq_pkg for register indexes and reset values, and on the filter RTL.
`timescale 1ns / 1ps

module tb_multichannel_biquad_filter;

  localparam int NCH = 2;

  // Register indexes that decode to nothing; writes to them must leave every
  // coefficient and the gain untouched.
  localparam logic [2:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [2:0] IDX_UNUSED_HI = 3'd7;

  // One filtered item as it leaves the block.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         chan;
  } filtered_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = mbq_pkg::REG_B0;
  logic [19:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] sample_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] sample_out;
  logic [3:0]         channel;

  multichannel_biquad_filter #(
    .NUM_CHANNELS(NCH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample_out(sample_out),
    .channel   (channel)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the filter: coefficients start at their reset values
  // (unity pass-through, unity gain) and every channel history starts cleared.
  logic signed [19:0] b0_q = mbq_pkg::B0_RESET;
  logic signed [19:0] b1_q = '0;
  logic signed [19:0] b2_q = '0;
  logic signed [19:0] a1_q = '0;
  logic signed [19:0] a2_q = '0;
  logic [15:0]        gain_q = mbq_pkg::GAIN_RESET;
  int                 ch_ptr = 0;
  logic signed [15:0] x_hist1 [NCH] = '{default: '0};
  logic signed [15:0] x_hist2 [NCH] = '{default: '0};
  logic signed [15:0] y_hist1 [NCH] = '{default: '0};
  logic signed [15:0] y_hist2 [NCH] = '{default: '0};

  // Filtered items still owed by the block, oldest first.
  filtered_t expected_samples[$];

  int errors = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int settings_loaded = 0;

  // Idle rates in percent; the test sequence changes them between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Computes the filtered item for one input sample on the current channel and
  // advances that channel's history and the channel pointer. The five products
  // are summed exactly, then scaled by 2^-16 with round half up and clamped;
  // that clamped value is what goes into the output history. The gain stage
  // scales by 2^-14 with round half up and clamps again.
  function automatic filtered_t biquad_model(input logic signed [15:0] x);
    filtered_t          r;
    longint             acc;
    logic signed [15:0] y;
    acc = longint'(b0_q) * longint'(x)
        + longint'(b1_q) * longint'(x_hist1[ch_ptr])
        + longint'(b2_q) * longint'(x_hist2[ch_ptr])
        - longint'(a1_q) * longint'(y_hist1[ch_ptr])
        - longint'(a2_q) * longint'(y_hist2[ch_ptr]);
    y = clamp16((acc + 64'sd32768) >>> 16);
    x_hist2[ch_ptr] = x_hist1[ch_ptr];
    y_hist2[ch_ptr] = y_hist1[ch_ptr];
    x_hist1[ch_ptr] = x;
    y_hist1[ch_ptr] = y;
    r.sample = clamp16((longint'(y) * longint'(gain_q) + 64'sd8192) >>> 14);
    r.chan   = 4'(ch_ptr);
    ch_ptr   = (ch_ptr + 1 == NCH) ? 0 : ch_ptr + 1;
    return r;
  endfunction

  // Drives one register write and mirrors it in the shadow copy. The write
  // enable is left high so that back-to-back writes need no idle gap; the
  // caller lowers it after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      mbq_pkg::REG_B0:   b0_q = data;
      mbq_pkg::REG_B1:   b1_q = data;
      mbq_pkg::REG_B2:   b2_q = data;
      mbq_pkg::REG_A1:   a1_q = data;
      mbq_pkg::REG_A2:   a2_q = data;
      mbq_pkg::REG_GAIN: gain_q = data[15:0];
      default:  ;
    endcase
  endtask

  task automatic load_coefs(input logic [19:0] b0, input logic [19:0] b1,
                            input logic [19:0] b2, input logic [19:0] a1,
                            input logic [19:0] a2, input logic [19:0] gain);
    write_reg(mbq_pkg::REG_B0, b0);
    write_reg(mbq_pkg::REG_B1, b1);
    write_reg(mbq_pkg::REG_B2, b2);
    write_reg(mbq_pkg::REG_A1, a1);
    write_reg(mbq_pkg::REG_A2, a2);
    write_reg(mbq_pkg::REG_GAIN, gain);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Offers one sample, idling first at the current sender rate. While idle the
  // sample port carries noise, which the block must not pick up. The payload
  // holds still until the block takes it, and only then is the item predicted.
  // The stall is read in mid-cycle, where it already holds the value that the
  // next rising edge sees.
  task automatic send_sample(input logic signed [15:0] x);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      sample_in <= 16'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    expected_samples.push_back(biquad_model(x));
    samples_sent++;
  endtask

  // Stops offering items until every owed item has come back. Always waits on
  // a clock edge so that the next drive lands in a fresh time step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_samples.size() != 0);
  endtask

  // Coefficient picker: mostly moderate values within +/-reach, with the two
  // range ends, zero and fully random words mixed in.
  function automatic logic [19:0] pick_coef(input int reach);
    case ($urandom_range(7))
      0:       return 20'h7ffff;
      1:       return 20'h80000;
      2:       return 20'($urandom);
      3:       return '0;
      default: return 20'($urandom_range(2 * reach) - reach);
    endcase
  endfunction

  // Gain picker: usually near unity, sometimes anything. The top four bits of
  // the written word are random and must be dropped by the block.
  function automatic logic [19:0] pick_gain();
    case ($urandom_range(5))
      0:       return {4'($urandom), 16'hffff};
      1:       return {4'($urandom), 16'h0000};
      2:       return 20'($urandom);
      default: return {4'($urandom), 16'($urandom_range(24000, 8000))};
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom_range(512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // The receiver stalls at the current rate, decided fresh at every edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Every item the block hands over is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    filtered_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected item sample_out=%0d channel=%0d",
                 $time, sample_out, channel);
      end else begin
        want = expected_samples.pop_front();
        results_seen++;
        if (sample_out !== want.sample) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, want.sample, sample_out);
        end
        if (channel !== want.chan) begin
          errors++;
          $display("%0t: channel mismatch, expected %0d, got %0d",
                   $time, want.chan, channel);
        end
      end
    end
  end

  // Right out of reset the block must pass samples through unchanged, which
  // also shows that every history starts cleared.
  task automatic test_reset_defaults();
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    wait_drained();
  endtask

  // Every coefficient at one end of its range and the gain at its maximum,
  // so that both the filter sum and the gain stage clamp in both directions.
  // Then a zero gain, which must silence the output whatever the filter does.
  task automatic test_coef_extremes();
    load_coefs(20'h7ffff, 20'h80000, 20'h7ffff, 20'h80000, 20'h7ffff, 20'h0ffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sd300);
    wait_drained();
    load_coefs(20'h80000, 20'h7ffff, 20'h80000, 20'h7ffff, 20'h80000, 20'h00000);
    send_sample(16'sd1000);
    send_sample(-16'sd1000);
    wait_drained();
  endtask

  // Bits above the gain width are dropped, and writes to the two unused
  // indexes change nothing, so the filter stays a unity pass-through.
  task automatic test_register_quirks();
    load_coefs(20'h10000, 20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'hf4000);
    send_sample(16'sd12345);
    wait_drained();
    write_reg(IDX_UNUSED_LO, 20'hfffff);
    write_reg(IDX_UNUSED_HI, 20'h80000);
    cfg_we <= 1'b0;
    send_sample(-16'sd20000);
    wait_drained();
  endtask

  // Half a coefficient and half a gain put both rounding steps exactly on a
  // tie, where round half up sends positive and negative values differently.
  task automatic test_rounding_ties();
    load_coefs(20'h08000, 20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h02000);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    wait_drained();
  endtask

  // Random samples in blocks; before each block the sender waits until the
  // block has handed back everything, then a fresh coefficient set goes in.
  // Feedback coefficients stay smaller on average so that most sets leave the
  // filter out of hard saturation and the history path stays visible.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int done;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < n_items) begin
      wait_drained();
      load_coefs(pick_coef(131072), pick_coef(131072), pick_coef(131072),
                 pick_coef(65536), pick_coef(32768), pick_gain());
      repeat (90) begin
        send_sample(pick_sample());
        done++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_coef_extremes();
    test_register_quirks();
    test_rounding_ties();

    // Sender mostly busy with a sluggish receiver, then the reverse, then
    // both sides at full rate.
    test_random_traffic(20, 78, 630);
    test_random_traffic(78, 20, 630);
    test_random_traffic(0, 0, 630);

    // Everything is back; leave room for any stray item to show up.
    wait_drained();
    repeat (12) @(posedge clk);

    $display("Covered %0d samples across %0d channels under %0d coefficient sets,",
             samples_sent, NCH, settings_loaded);
    $display("with clamping, rounding ties and ignored writes; %0d items checked.",
             results_seen);
    if (errors == 0) begin
      $display("PASS multichannel_biquad_filter");
    end else begin
      $display("FAIL multichannel_biquad_filter");
    end
    $finish;
  end

  // Far beyond the slowest legal run of this sequence.
  initial begin
    #(4_000_000);
    $display("FAIL multichannel_biquad_filter");
    $finish;
  end

endmodule
